// ===== rtl/ins_sort_pkg.sv =====
package ins_sort_pkg;

    localparam int MAX_COUNT = 32;
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_value;
        logic                     last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } out_item_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                     insert;
        logic                     shift;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ===== rtl/ins_sort_cell.sv =====
module ins_sort_cell
    import ins_sort_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_cmd_t                cmd,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic                     left_valid,
    input  logic                     left_greater,
    input  logic signed [DATA_W-1:0] right_value,
    input  logic                     right_valid,
    output logic signed [DATA_W-1:0] value,
    output logic                     valid,
    output logic                     greater
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     valid_reg;
    logic                     valid_next;

    // An empty cell counts as greater than anything, so the insert point
    // falls on the first free cell when no stored value is larger.
    assign greater = !valid_reg || (value_reg > cmd.value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (cmd.shift)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (cmd.insert && greater)
        begin
            value_next = left_greater ? left_value : cmd.value;
            valid_next = valid_reg || left_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/insertion_sorter.sv =====
// Sorts a set of up to MAX_COUNT signed 32-bit values. One value is taken per
// clock while busy is low; each goes straight into its place in a chain of
// cells, so inserting never stalls. The transaction with last_in set closes the
// set: starting the next cycle, busy stays high while the chain shifts out one
// value per cycle in ascending order, each shown for one cycle with strobe high.
// The receiver cannot stall the results, so it must take every strobe. Values
// arriving while the chain is full are dropped and overflow is reported on every
// result of that set.
module insertion_sorter
    import ins_sort_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      strobe,
    output out_item_t result
);

    logic                     drain_reg;
    logic                     drain_next;
    logic                     overflow_reg;
    logic                     overflow_next;
    logic                     accept;
    logic                     full;
    cell_cmd_t                cmd;

    logic signed [DATA_W-1:0] cell_value   [MAX_COUNT];
    logic                     cell_valid   [MAX_COUNT];
    logic                     cell_greater [MAX_COUNT];

    assign accept     = start && !drain_reg;
    assign full       = cell_valid[MAX_COUNT-1];
    assign cmd.insert = accept && !full;
    assign cmd.shift  = drain_reg;
    assign cmd.value  = item.data_value;

    for (genvar i = 0; i < MAX_COUNT; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] l_value;
        logic                     l_valid;
        logic                     l_greater;
        logic signed [DATA_W-1:0] r_value;
        logic                     r_valid;

        if (i == 0)
        begin : g_head
            assign l_value   = '0;
            assign l_valid   = 1'b1;
            assign l_greater = 1'b0;
        end
        else
        begin : g_body
            assign l_value   = cell_value[i-1];
            assign l_valid   = cell_valid[i-1];
            assign l_greater = cell_greater[i-1];
        end

        if (i == MAX_COUNT - 1)
        begin : g_tail
            assign r_value = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid
            assign r_value = cell_value[i+1];
            assign r_valid = cell_valid[i+1];
        end

        ins_sort_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .left_value   (l_value),
            .left_valid   (l_valid),
            .left_greater (l_greater),
            .right_value  (r_value),
            .right_valid  (r_valid),
            .value        (cell_value[i]),
            .valid        (cell_valid[i]),
            .greater      (cell_greater[i])
        );
    end

    always_comb
    begin
        drain_next    = drain_reg;
        overflow_next = overflow_reg;
        if (drain_reg)
        begin
            // the head is the final value once its neighbor is empty
            if (!cell_valid[1])
            begin
                drain_next    = 1'b0;
                overflow_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            if (item.last_in)
            begin
                drain_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg    <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            drain_reg    <= drain_next;
            overflow_reg <= overflow_next;
        end
    end

    assign busy                = drain_reg;
    assign strobe              = drain_reg;
    assign result.sorted_value = cell_value[0];
    assign result.last_out     = !cell_valid[1];
    assign result.overflow     = overflow_reg;

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import ins_sort_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_item_t  item;
    logic      busy;
    logic      strobe;
    out_item_t result;

    insertion_sorter u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    // Predicted contents of the sort chain
    logic signed [DATA_W-1:0] held_vals [MAX_COUNT];
    int                       held_count = 0;
    bit                       held_dropped = 1'b0;
    out_item_t                sorted_due [$];

    int errors  = 0;
    int gap_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic predict_sorted(input in_item_t it);
        int        pos;
        out_item_t r;
        if (held_count < MAX_COUNT)
        begin
            pos = held_count;
            // equal values stay behind earlier arrivals
            while (pos > 0 && held_vals[pos-1] > $signed(it.data_value))
            begin
                held_vals[pos] = held_vals[pos-1];
                pos--;
            end
            held_vals[pos] = it.data_value;
            held_count++;
        end
        else
            held_dropped = 1'b1;

        if (it.last_in)
        begin
            for (int k = 0; k < held_count; k++)
            begin
                r.sorted_value = held_vals[k];
                r.last_out     = (k == held_count - 1);
                r.overflow     = held_dropped;
                sorted_due.push_back(r);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    // Results are checked before the transaction of the same edge is predicted.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && strobe)
        begin
            if (sorted_due.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d last=%0b overflow=%0b",
                         $time, result.sorted_value, result.last_out, result.overflow);
                errors++;
            end
            else
            begin
                want = sorted_due.pop_front();
                if (result.sorted_value !== want.sorted_value)
                begin
                    $display("%0t: sorted_value expected %0d, got %0d",
                             $time, want.sorted_value, result.sorted_value);
                    errors++;
                end
                if (result.last_out !== want.last_out)
                begin
                    $display("%0t: last_out expected %0b, got %0b",
                             $time, want.last_out, result.last_out);
                    errors++;
                end
                if (result.overflow !== want.overflow)
                begin
                    $display("%0t: overflow expected %0b, got %0b",
                             $time, want.overflow, result.overflow);
                    errors++;
                end
            end
        end
        if (rst_n && start && !busy)
            predict_sorted(item);
    end

    task automatic send_item(input logic signed [DATA_W-1:0] v, input bit last);
        int idle;
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            idle = $urandom_range(1, 4);
            repeat (idle) @(posedge clk);
        end
        start <= 1'b1;
        item  <= '{data_value: v, last_in: last};
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (sorted_due.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    // Mix of extremes, a narrow range for duplicates, and full-width values
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return $signed($urandom_range(8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_item(pick_value(), i == n - 1);
    endtask

    task automatic test_edges();
        send_item(32'sh8000_0000, 1'b1);
        send_item(32'sh7fff_ffff, 1'b1);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b1);
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(-5, 1'b0);
        send_item(5, 1'b1);
        send_item(3, 1'b0);
        send_item(2, 1'b0);
        send_item(1, 1'b1);
    endtask

    // Full chain, drop of the closing transaction, and several drops in a row
    task automatic test_overflow();
        send_set(MAX_COUNT);
        send_set(MAX_COUNT + 1);
        send_set(MAX_COUNT + 5);
    endtask

    task automatic test_random(input int budget);
        int sent;
        int n;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(9) == 0)
                n = $urandom_range(MAX_COUNT - 2, MAX_COUNT + 3);
            else
                n = $urandom_range(1, 8);
            send_set(n);
            sent += n;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 15;
        test_edges();
        test_overflow();
        wait_idle();
        test_random(60);

        gap_pct = 54;
        test_random(60);
        wait_idle();

        gap_pct = 0;
        test_random(60);

        wait_idle();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
